// File: rtl/sack_hp_pkg.sv
// shared types, constants and codes of the selective-ack header parser
package sack_hp_pkg;

	localparam int MAX_ACK_PAIRS      = 32;
	localparam int ACK_FLAG_BIT       = 0;
	localparam int MAX_DATAGRAM_BYTES = 2048;

	localparam logic [15:0] HDR_BYTES         = 16'd16;
	localparam logic [2:0]  PAIR_LAST_BYTE    = 3'd7;
	localparam int          VERSION_SHIFT     = 12;
	localparam logic [15:0] MAX_PAYLOAD_RESET = 16'(MAX_DATAGRAM_BYTES - 16);
	localparam logic [15:0] ACK_PAIR_LIMIT    = 16'(MAX_ACK_PAIRS);

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_SHORT_HDR  = 3'd1;
	localparam logic [2:0] ST_SHORT_ACKS = 3'd2;
	localparam logic [2:0] ST_MANY_PAIRS = 3'd3;
	localparam logic [2:0] ST_PAIR_ORDER = 3'd4;
	localparam logic [2:0] ST_DATA_LEN   = 3'd5;

	localparam logic KIND_PAIR    = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	typedef struct packed {
		logic [7:0] byte_in;
		logic       end_of_datagram;
	} in_item_t;

	typedef struct packed {
		logic        item_kind;
		logic        last_of_run;
		logic        header_valid;
		logic [2:0]  status_code;
		logic [11:0] flag_bits;
		logic [3:0]  version_out;
		logic [15:0] length_field;
		logic [31:0] sequence_id;
		logic [63:0] packet_number;
		logic [31:0] pair_left;
		logic [31:0] pair_right;
		logic [15:0] bytes_consumed;
	} out_item_t;

	// results produced by one byte, pushed into the output queue
	typedef struct packed {
		logic [1:0] count;
		out_item_t  first;
		out_item_t  second;
	} res_push_t;

endpackage

// File: rtl/sack_hp_core.sv
// datagram state, header assembly, pair checks and verdict for one byte
module sack_hp_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   go,
	input  sack_hp_pkg::in_item_t  item_s1,
	input  logic                   cfg_we,
	input  logic [15:0]            cfg_wdata,
	output sack_hp_pkg::res_push_t res
);

	logic [15:0] max_payload_q;
	logic [15:0] byte_count_q;
	logic [15:0] raw_flags_q;
	logic [15:0] raw_length_q;
	logic [31:0] raw_sequence_q;
	logic [63:0] raw_packet_id_q;
	logic [63:0] pair_shift_q;
	logic [31:0] previous_right_q;
	logic [7:0]  pairs_seen_q;
	logic [2:0]  latched_error_q;

	logic [15:0] byte_count_d;
	logic [15:0] raw_flags_d;
	logic [15:0] raw_length_d;
	logic [31:0] raw_sequence_d;
	logic [63:0] raw_packet_id_d;
	logic [63:0] pair_shift_d;
	logic [31:0] previous_right_d;
	logic [7:0]  pairs_seen_d;
	logic [2:0]  latched_error_d;

	logic [7:0]  b;
	logic        last;
	logic        in_pairs;
	logic        pair_done;
	logic [63:0] shifted;
	logic [31:0] pl;
	logic [31:0] pr;
	logic [31:0] d_lr;
	logic [31:0] d_lp;
	logic        bad_order;
	logic        is_ack_d;
	logic [15:0] payload;
	logic [18:0] need;
	logic [18:0] consumed_w;
	logic [15:0] consumed;
	logic [2:0]  status;
	sack_hp_pkg::out_item_t pair_item;
	sack_hp_pkg::out_item_t verdict_item;

	assign b    = item_s1.byte_in;
	assign last = item_s1.end_of_datagram;

	always_comb begin
		raw_flags_d      = raw_flags_q;
		raw_length_d     = raw_length_q;
		raw_sequence_d   = raw_sequence_q;
		raw_packet_id_d  = raw_packet_id_q;
		pair_shift_d     = pair_shift_q;
		previous_right_d = previous_right_q;
		pairs_seen_d     = pairs_seen_q;
		latched_error_d  = latched_error_q;
		shifted          = {pair_shift_q[55:0], b};
		pl               = shifted[63:32];
		pr               = shifted[31:0];
		d_lr             = pl - pr;
		d_lp             = pl - (previous_right_q + 32'd1);
		bad_order        = ((d_lr != 32'd0) && !d_lr[31]) || !((d_lp != 32'd0) && !d_lp[31]);
		in_pairs         = 1'b0;
		pair_done        = 1'b0;
		if (byte_count_q < sack_hp_pkg::HDR_BYTES) begin
			priority if (byte_count_q < 16'd2) begin
				raw_flags_d = {raw_flags_q[7:0], b};
			end else if (byte_count_q < 16'd4) begin
				raw_length_d = {raw_length_q[7:0], b};
			end else if (byte_count_q < 16'd8) begin
				raw_sequence_d = {raw_sequence_q[23:0], b};
			end else begin
				raw_packet_id_d = {raw_packet_id_q[55:0], b};
			end
			if (byte_count_q == sack_hp_pkg::HDR_BYTES - 16'd1) begin
				previous_right_d = raw_sequence_q - 32'd1;
			end
		end else begin
			in_pairs = raw_flags_q[sack_hp_pkg::ACK_FLAG_BIT] && (raw_length_q != 16'd0) &&
				(raw_length_q <= sack_hp_pkg::ACK_PAIR_LIMIT) &&
				({8'd0, pairs_seen_q} < raw_length_q);
			if (in_pairs) begin
				pair_shift_d = shifted;
				if (byte_count_q[2:0] == sack_hp_pkg::PAIR_LAST_BYTE) begin
					pair_done = 1'b1;
					if ((latched_error_q == sack_hp_pkg::ST_OK) && bad_order) begin
						latched_error_d = sack_hp_pkg::ST_PAIR_ORDER;
					end
					previous_right_d = pr;
					pairs_seen_d     = pairs_seen_q + 8'd1;
					pair_shift_d     = 64'd0;
				end
			end
		end
		byte_count_d = (byte_count_q != 16'hFFFF) ? byte_count_q + 16'd1 : byte_count_q;
	end

	// verdict from the state after this byte
	always_comb begin
		is_ack_d   = raw_flags_d[sack_hp_pkg::ACK_FLAG_BIT];
		payload    = byte_count_d - sack_hp_pkg::HDR_BYTES;
		need       = {raw_length_d, 3'b000};
		consumed_w = 19'(sack_hp_pkg::HDR_BYTES);
		status     = sack_hp_pkg::ST_OK;
		if (byte_count_d < sack_hp_pkg::HDR_BYTES) begin
			status = sack_hp_pkg::ST_SHORT_HDR;
		end else if (is_ack_d) begin
			if (raw_length_d != 16'd0) begin
				consumed_w = 19'(sack_hp_pkg::HDR_BYTES) + need;
				priority if ({3'b000, payload} < need) begin
					status = sack_hp_pkg::ST_SHORT_ACKS;
				end else if (raw_length_d > sack_hp_pkg::ACK_PAIR_LIMIT) begin
					status = sack_hp_pkg::ST_MANY_PAIRS;
				end else if ({3'b000, payload} != need) begin
					status = sack_hp_pkg::ST_DATA_LEN;
				end else if (latched_error_d != sack_hp_pkg::ST_OK) begin
					status = latched_error_d;
				end
			end else if (payload != 16'd0) begin
				status = sack_hp_pkg::ST_DATA_LEN;
			end
		end else if ((raw_length_d == 16'd0) || (raw_length_d > max_payload_q) ||
				(raw_length_d != payload)) begin
			status = sack_hp_pkg::ST_DATA_LEN;
		end
		consumed = consumed_w[15:0];
	end

	always_comb begin
		pair_item             = '0;
		pair_item.item_kind   = sack_hp_pkg::KIND_PAIR;
		pair_item.last_of_run = !last;
		pair_item.pair_left   = pl;
		pair_item.pair_right  = pr;

		verdict_item              = '0;
		verdict_item.item_kind    = sack_hp_pkg::KIND_VERDICT;
		verdict_item.last_of_run  = 1'b1;
		verdict_item.header_valid = (status == sack_hp_pkg::ST_OK);
		verdict_item.status_code  = status;
		if (byte_count_d >= sack_hp_pkg::HDR_BYTES) begin
			verdict_item.flag_bits     = raw_flags_d[11:0];
			verdict_item.version_out   = raw_flags_d[15:sack_hp_pkg::VERSION_SHIFT];
			verdict_item.length_field  = raw_length_d;
			verdict_item.sequence_id   = raw_sequence_d;
			verdict_item.packet_number = raw_packet_id_d;
		end
		verdict_item.bytes_consumed = (status == sack_hp_pkg::ST_OK) ? consumed : 16'd0;

		res.count  = {1'b0, pair_done} + {1'b0, last};
		res.first  = pair_done ? pair_item : verdict_item;
		res.second = verdict_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= sack_hp_pkg::MAX_PAYLOAD_RESET;
		end else if (cfg_we) begin
			max_payload_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q     <= '0;
			raw_flags_q      <= '0;
			raw_length_q     <= '0;
			raw_sequence_q   <= '0;
			raw_packet_id_q  <= '0;
			pair_shift_q     <= '0;
			previous_right_q <= '0;
			pairs_seen_q     <= '0;
			latched_error_q  <= '0;
		end else if (go) begin
			if (last) begin
				byte_count_q     <= '0;
				raw_flags_q      <= '0;
				raw_length_q     <= '0;
				raw_sequence_q   <= '0;
				raw_packet_id_q  <= '0;
				pair_shift_q     <= '0;
				previous_right_q <= '0;
				pairs_seen_q     <= '0;
				latched_error_q  <= '0;
			end else begin
				byte_count_q     <= byte_count_d;
				raw_flags_q      <= raw_flags_d;
				raw_length_q     <= raw_length_d;
				raw_sequence_q   <= raw_sequence_d;
				raw_packet_id_q  <= raw_packet_id_d;
				pair_shift_q     <= pair_shift_d;
				previous_right_q <= previous_right_d;
				pairs_seen_q     <= pairs_seen_d;
				latched_error_q  <= latched_error_d;
			end
		end
	end

endmodule

// File: rtl/sack_hp_outq.sv
// two-entry result queue, takes up to two results per cycle, gives one while out_stall is low
module sack_hp_outq (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sack_hp_pkg::res_push_t push,
	output logic [1:0]             free,
	output logic                   out_valid,
	input  logic                   out_stall,
	output sack_hp_pkg::out_item_t out_data
);

	sack_hp_pkg::out_item_t ent0_q;
	sack_hp_pkg::out_item_t ent1_q;
	sack_hp_pkg::out_item_t ent0_d;
	sack_hp_pkg::out_item_t ent1_d;
	logic [1:0] count_q;
	logic [1:0] after_pop;
	logic       pop;

	assign out_valid = (count_q != 2'd0);
	assign out_data  = ent0_q;
	assign free      = 2'd2 - count_q;
	assign pop       = out_valid && !out_stall;
	assign after_pop = count_q - {1'b0, pop};

	always_comb begin
		ent0_d = pop ? ent1_q : ent0_q;
		ent1_d = ent1_q;
		if (push.count != 2'd0) begin
			if (after_pop[0]) begin
				ent1_d = push.first;
			end else begin
				ent0_d = push.first;
			end
		end
		if (push.count == 2'd2) begin
			ent1_d = push.second;
		end
	end

	always_ff @(posedge clk) begin
		ent0_q <= ent0_d;
		ent1_q <= ent1_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= after_pop + push.count;
		end
	end

endmodule

// File: rtl/sack_header_parser.sv
// top level of the selective-ack datagram header parser
// One byte per transaction is accepted every cycle while in_stall is low. A byte is
// registered, then parsed against the datagram state and its results enter a two-entry
// output queue; a result passes the input register and then a queue entry before it
// appears. Most bytes give no result or one; a byte that both completes an ack pair and
// ends the datagram gives two, and the input register then holds its byte until the queue
// has two free entries. The byte before it never gives a result, so with an unstalled
// output the queue is empty by then and no cycle is lost; only out_stall can hold the
// input back. The register max_payload_q is written through cfg_we/cfg_wdata, resets to 2032.
module sack_header_parser (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  sack_hp_pkg::in_item_t  in_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output sack_hp_pkg::out_item_t out_data,
	input  logic                   cfg_we,
	input  logic [15:0]            cfg_wdata
);

	logic                   valid_s1;
	sack_hp_pkg::in_item_t  item_s1;
	sack_hp_pkg::res_push_t res;
	sack_hp_pkg::res_push_t push;
	logic [1:0]             free;
	logic                   go;

	assign go       = valid_s1 && (res.count <= free);
	assign in_stall = valid_s1 && !go;

	always_comb begin
		push       = res;
		push.count = go ? res.count : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	sack_hp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (go),
		.item_s1   (item_s1),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.res       (res)
	);

	sack_hp_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.free      (free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
